FILE: sv/gwws_pkg.sv
// types, constants and helpers shared by the word wrap splitter
// no dependencies
package gwws_pkg;

   localparam logic [7:0]  CH_SPACE      = 8'd32;
   localparam logic [7:0]  CH_NEWLINE    = 8'd10;
   localparam logic [9:0]  WIDTH_RESET   = 10'd80;
   localparam logic [15:0] POS_CAP       = 16'hFFFF;
   localparam logic [15:0] IDX_MAX       = 16'hFFFF;
   localparam int          FIFO_DEPTH    = 4;
   localparam int          FIFO_PTR_W    = $clog2(FIFO_DEPTH);
   localparam int          FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [15:0] seg_begin;
      logic [15:0] seg_end;
      logic        final_segment;
   } rsp_type;

   // results of one step: an optional mid-string segment and an optional final one
   typedef struct packed {
      logic    mid_valid;
      rsp_type mid;
      logic    fin_valid;
      rsp_type fin;
   } step_out_type;

   // saturate a 17-bit index to the 16-bit field
   function automatic logic [15:0] clamp_idx(input logic [16:0] v);
      logic [15:0] r;
      r = v[16] ? IDX_MAX : v[15:0];
      return r;
   endfunction

endpackage

FILE: sv/gwws_step.sv
// per-byte wrap logic: position, last space and last break registers
// depends on gwws_pkg
module gwws_step
   import gwws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_type      item,
   input  logic [9:0]   width_limit,
   output step_out_type step_out
);

   logic [15:0] char_pos_ff, char_pos_in;
   logic [16:0] space_p1_ff, space_p1_in;
   logic [16:0] break_p1_ff, break_p1_in;

   logic        wr_on, is_space, is_nl, wbreak, hard;
   logic [16:0] i1, sp_a, bp_a, since, gap, width_x;
   logic [16:0] sp_b, bp_b;

   assign wr_on   = (width_limit != '0);
   assign is_space = (item.text_byte == CH_SPACE);
   assign is_nl    = (item.text_byte == CH_NEWLINE);
   assign i1       = {1'b0, char_pos_ff} + 17'd1;
   assign width_x  = {7'b0, width_limit};

   // space and newline update
   always_comb begin
      sp_a = space_p1_ff;
      bp_a = break_p1_ff;
      if (is_space) begin
         sp_a = i1;
      end else if (is_nl) begin
         sp_a = i1;
         bp_a = i1;
      end
   end

   // width check on the updated marks
   assign since  = (bp_a <= i1) ? (i1 - bp_a) : '0;
   assign gap    = (sp_a <= i1) ? (i1 - sp_a) : '0;
   assign wbreak = wr_on && (since >= width_x);
   assign hard   = (sp_a == '0) || (gap >= width_x);

   always_comb begin
      sp_b = sp_a;
      bp_b = bp_a;
      step_out = '0;
      if (wr_on && is_nl) begin
         step_out.mid_valid = 1'b1;
         step_out.mid.seg_begin = clamp_idx(break_p1_ff);
         step_out.mid.seg_end   = char_pos_ff;
      end else if (wbreak) begin
         step_out.mid_valid = 1'b1;
         step_out.mid.seg_begin = clamp_idx(bp_a);
         if (hard) begin
            step_out.mid.seg_end = char_pos_ff;
            bp_b = i1;
         end else begin
            step_out.mid.seg_end = clamp_idx(sp_a - 17'd1);
            bp_b = sp_a;
         end
      end
      if (!wr_on) begin
         sp_b = space_p1_ff;
         bp_b = break_p1_ff;
      end
      // flush of the last segment
      step_out.fin_valid = wr_on && item.end_of_text;
      step_out.fin.seg_begin = clamp_idx(bp_b);
      step_out.fin.seg_end   = clamp_idx(i1);
      step_out.fin.final_segment = 1'b1;
   end

   // next state
   always_comb begin
      char_pos_in = char_pos_ff;
      space_p1_in = space_p1_ff;
      break_p1_in = break_p1_ff;
      if (fire) begin
         if (item.end_of_text) begin
            char_pos_in = '0;
            space_p1_in = '0;
            break_p1_in = '0;
         end else begin
            space_p1_in = sp_b;
            break_p1_in = bp_b;
            if (char_pos_ff < POS_CAP) begin
               char_pos_in = i1[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_pos_ff <= '0;
         space_p1_ff <= '0;
         break_p1_ff <= '0;
      end else begin
         char_pos_ff <= char_pos_in;
         space_p1_ff <= space_p1_in;
         break_p1_ff <= break_p1_in;
      end
   end

endmodule

FILE: sv/gwws_rsp_fifo.sv
// small result queue, up to two pushes and one pop per cycle
// depends on gwws_pkg
module gwws_rsp_fifo
   import gwws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  step_out_type step_out,
   output logic         has_room,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   rsp_type                entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [1:0]            n_push;
   logic                  pop;
   rsp_type               first, second;

   // order the beats of one step
   always_comb begin
      n_push = 2'd0;
      first  = step_out.fin;
      second = step_out.fin;
      if (push) begin
         if (step_out.mid_valid) begin
            first  = step_out.mid;
            n_push = step_out.fin_valid ? 2'd2 : 2'd1;
         end else if (step_out.fin_valid) begin
            n_push = 2'd1;
         end
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entries_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign has_room  = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         entries_ff[wr_ptr_ff] <= first;
      end
      if (n_push == 2'd2) begin
         entries_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= second;
      end
   end

endmodule

FILE: sv/greedy_word_wrap_splitter_core.sv
// greedy word wrap splitter: one text byte a beat in, line segments out
// depends on gwws_pkg, gwws_step, gwws_rsp_fifo
// path: accepted byte -> input register -> result queue (written once it has room) -> rsp
// throughput: one byte per cycle while the result queue has room; a byte with two segments
//   yields two queue entries, read one at a time from the single-read result queue of four entries
// reset: synchronous, clears position, marks and queue; width_limit returns to 80
module greedy_word_wrap_splitter_core
   import gwws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [9:0] csr_write_data
);

   logic [9:0]   width_ff;
   logic         in_valid_ff, in_valid_in;
   req_type      in_data_ff;
   logic         has_room, fire, accept;
   step_out_type step_out;

   // width register
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_write_enable) begin
         width_ff <= csr_write_data;
      end
   end

   // input register
   assign fire      = in_valid_ff && has_room;
   assign req_stall = in_valid_ff && !has_room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   gwws_step u_step (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (in_data_ff),
      .width_limit (width_ff),
      .step_out    (step_out)
   );

   gwws_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .step_out  (step_out),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
